/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked from the next edge onwards.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cor_pkg.sv */
// Types and constants of the circle outline rasteriser.
`timescale 1ns / 1ps

package cor_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned RAD_W   = 9;
    localparam int unsigned PIX_W   = 12;
    localparam int unsigned CLIP_W  = 11;
    localparam int unsigned DEC_W   = 14;
    localparam int unsigned IDX_W   = 3;

    // Operation codes of an input beat
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam logic REG_CLIP_WIDTH  = 1'b0;
    localparam logic REG_CLIP_HEIGHT = 1'b1;

    localparam logic [CLIP_W-1:0] CLIP_WIDTH_RESET  = 11'd640;
    localparam logic [CLIP_W-1:0] CLIP_HEIGHT_RESET = 11'd320;

    localparam logic [IDX_W-1:0] LAST_POINT = 3'd7;

    typedef struct packed {
        logic              op;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [RAD_W-1:0]   radius;
    } t_in_beat;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    visible;
        logic                    last;
        logic                    finished;
    } t_out_beat;

    // Offsets and centre of one step, handed to the point sequencer
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               fin;
    } t_snap;

endpackage

/* hdl/cor_step.sv */
// Midpoint state and one-step update of the circle outline rasteriser.
`timescale 1ns / 1ps

module cor_step
    import cor_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_data,
    output logic     o_emit,
    output t_snap    o_snap
);

    logic [COORD_W-1:0] r_cx, r_cy, r_ox, r_oy;
    logic [DEC_W-1:0]   r_dec;
    logic               r_active;

    logic               start;
    logic [COORD_W-1:0] cur_cx, cur_cy, cur_x, cur_y;
    logic [DEC_W-1:0]   cur_p;
    logic [PIX_W-1:0]   nx, ny;
    logic [DEC_W-1:0]   n_dec;
    logic               dec_neg, fin;

    assign start = (i_data.op == OP_START);

    always_comb begin
        if (start) begin
            cur_cx = i_data.center_x;
            cur_cy = i_data.center_y;
            cur_x  = '0;
            cur_y  = {1'b0, i_data.radius};
            cur_p  = DEC_W'(3) - {{(DEC_W-RAD_W-1){1'b0}}, i_data.radius, 1'b0};
        end else begin
            cur_cx = r_cx;
            cur_cy = r_cy;
            cur_x  = r_ox;
            cur_y  = r_oy;
            cur_p  = r_dec;
        end
    end

    assign dec_neg = cur_p[DEC_W-1];
    assign nx      = {2'b00, cur_x} + PIX_W'(1);
    assign ny      = {2'b00, cur_y} - {{(PIX_W-1){1'b0}}, ~dec_neg};
    assign fin     = $signed(nx) > $signed(ny);

    // Decision update, kept modulo 2^14
    always_comb begin
        if (dec_neg) begin
            n_dec = cur_p + {nx[DEC_W-3:0], 2'b00} + DEC_W'(6);
        end else begin
            n_dec = cur_p + {nx[DEC_W-3:0] - {2'b00, cur_y}, 2'b00} + DEC_W'(10);
        end
    end

    assign o_emit = i_accept && (start || r_active);

    assign o_snap.cx  = cur_cx;
    assign o_snap.cy  = cur_cy;
    assign o_snap.ox  = cur_x;
    assign o_snap.oy  = cur_y;
    assign o_snap.fin = fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_emit) begin
            r_active <= ~fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_emit) begin
            r_cx  <= cur_cx;
            r_cy  <= cur_cy;
            r_ox  <= nx[COORD_W-1:0];
            r_oy  <= ny[COORD_W-1:0];
            r_dec <= n_dec;
        end
    end

endmodule

/* hdl/cor_emit.sv */
// Point sequencer: eight symmetric points per step into a registered output.
`timescale 1ns / 1ps

module cor_emit
    import cor_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_snap             i_snap,
    input  logic [CLIP_W-1:0] i_clip_width,
    input  logic [CLIP_W-1:0] i_clip_height,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_beat         o_data
);

    t_snap            r_snap;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic               load_out, idx_last, swap, neg_x, neg_y;
    logic [COORD_W-1:0] off_a, off_b;
    logic [PIX_W-1:0]   px, py;
    t_out_beat          n_out;

    assign load_out = r_busy && (!r_out_valid || !i_stall);
    assign idx_last = (r_idx == LAST_POINT);
    assign o_free   = !r_busy || (load_out && idx_last);

    // Octant selection from the point index
    assign swap  = r_idx[2];
    assign neg_x = swap ? r_idx[1] : r_idx[0];
    assign neg_y = swap ? r_idx[0] : r_idx[1];
    assign off_a = swap ? r_snap.oy : r_snap.ox;
    assign off_b = swap ? r_snap.ox : r_snap.oy;

    assign px = neg_x ? {2'b00, r_snap.cx} - {2'b00, off_a}
                      : {2'b00, r_snap.cx} + {2'b00, off_a};
    assign py = neg_y ? {2'b00, r_snap.cy} - {2'b00, off_b}
                      : {2'b00, r_snap.cy} + {2'b00, off_b};

    always_comb begin
        n_out.pixel_x  = $signed(px);
        n_out.pixel_y  = $signed(py);
        n_out.visible  = ($signed(px) > $signed(PIX_W'(0)))
                      && ($signed(px) < $signed({1'b0, i_clip_width}))
                      && ($signed(py) > $signed(PIX_W'(0)))
                      && ($signed(py) < $signed({1'b0, i_clip_height}));
        n_out.last     = idx_last;
        n_out.finished = r_snap.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new step may arrive on the edge the eighth point leaves
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (load_out) begin
                r_idx <= r_idx + IDX_W'(1);
                if (idx_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* hdl/circle_outline_rasterizer_core.sv */
// Top level of the midpoint circle outline rasteriser.
// A start beat (op = start) loads centre and radius; each start beat and each
// step beat while a circle is active yields eight outline points, one output
// beat per cycle unless the output stalls, in octant order, the eighth
// flagged last and all eight flagged finished when the circle completes with
// that step. A step beat with no active circle is absorbed and yields nothing.
// An emitting beat occupies the block until its eighth point enters the single
// output register, which takes one point per cycle unless stalled; the next
// input beat is taken in that cycle, so output beats follow with no gap. A
// beat's first point passes the step and output registers before it is
// presented. The user must write clip registers through the plain write port
// only while no points are pending; the block itself does not enforce it.
`timescale 1ns / 1ps

module circle_outline_rasterizer_core
    import cor_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    // output beats
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CLIP_W-1:0] i_cfg_data
);

    logic [CLIP_W-1:0] r_clip_width;
    logic [CLIP_W-1:0] r_clip_height;

    logic  in_accept;
    logic  emit;
    logic  emit_free;
    t_snap snap;

    // Clip window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_width  <= CLIP_WIDTH_RESET;
            r_clip_height <= CLIP_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLIP_WIDTH:  r_clip_width  <= i_cfg_data;
                REG_CLIP_HEIGHT: r_clip_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input is held off only while the sequencer still owes points
    assign o_in_stall = !emit_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Midpoint state: advances once per accepted emitting beat
    cor_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_data   (i_in_data),
        .o_emit   (emit),
        .o_snap   (snap)
    );

    // Eight points of the captured offsets, one per output beat
    cor_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (emit),
        .i_snap        (snap),
        .i_clip_width  (r_clip_width),
        .i_clip_height (r_clip_height),
        .o_free        (emit_free),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_data        (o_out_data)
    );

endmodule

/* hdl/cor_checker.sv */
// Port-level checker of the circle outline rasteriser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cor_checker
    import cor_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    logic out_take;
    logic out_held;
    logic vis_ok;
    logic last_take;
    logic last_clear;

    assign out_take   = o_out_valid && !i_out_stall;
    assign out_held   = o_out_valid && i_out_stall;
    // A visible point has both coordinates above zero
    assign vis_ok     = !o_out_valid || !o_out_data.visible
                     || (!o_out_data.pixel_x[PIX_W-1] && (o_out_data.pixel_x != '0)
                         && !o_out_data.pixel_y[PIX_W-1] && (o_out_data.pixel_y != '0));
    assign last_take  = out_take && o_out_data.last;
    assign last_clear = !o_out_valid || !o_out_data.last;

    `ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_held, o_out_valid, "stalled beat dropped")
    `ASSERT_NEXT(a_out_data_held, i_clk, i_rst_n, out_held, $stable(o_out_data), "stalled beat changed")
    `ASSERT_CLK(a_visible_positive, i_clk, i_rst_n, vis_ok, "visible point off the positive quadrant")
    `ASSERT_NEXT(a_last_isolated, i_clk, i_rst_n, last_take, last_clear, "two last points in a row")

endmodule

bind circle_outline_rasterizer_core cor_checker u_cor_checker (.*);

/* sim/circle_outline_rasterizer_core_tb.sv */
// Self-checking testbench for the midpoint circle outline rasteriser core.
`timescale 1ns / 1ps

module circle_outline_rasterizer_core_tb;
    import cor_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_beat         o_out_data;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CLIP_W-1:0] i_cfg_data;

    circle_outline_rasterizer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Input beat waiting to be sent; drain holds it back until all points are out
    typedef struct {
        t_in_beat beat;
        bit       drain;
    } t_pending;

    t_pending  beats_to_send[$];
    t_out_beat points_due[$];

    // Shadow copy of the rasteriser state and clip window
    logic [CLIP_W-1:0]       clip_w;
    logic [CLIP_W-1:0]       clip_h;
    logic [COORD_W-1:0]      ctr_x;
    logic [COORD_W-1:0]      ctr_y;
    logic [COORD_W-1:0]      off_x;
    logic [COORD_W-1:0]      off_y;
    logic signed [DEC_W-1:0] dec;
    bit                      circ_active;

    // Idling controls, changed per phase
    bit idle_in_en;
    bit idle_out_en;
    int gap_left;
    int stall_left;

    int n_beats_sent;
    int n_emitting;
    int n_points;
    int n_visible;
    int n_mismatch;
    int n_settings;

    t_out_beat want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Number of point-producing beats a full circle of radius r takes
    function automatic int circle_len(input int r);
        int x, y, d, n;
        x = 0;
        y = r;
        d = 3 - 2 * r;
        n = 0;
        do begin
            n++;
            x++;
            if (d < 0) begin
                d += 4 * x + 6;
            end else begin
                d += 4 * (x - y) + 10;
                y--;
            end
        end while (x <= y);
        return n;
    endfunction

    // Expected points of one accepted input beat, advancing the shadow state
    function automatic void predict_points(input t_in_beat b);
        int x, y, nx, ny, d, cxi, cyi;
        int px[8];
        int py[8];
        bit fin;
        t_out_beat pt;
        if (b.op == OP_START) begin
            ctr_x       = b.center_x;
            ctr_y       = b.center_y;
            off_x       = '0;
            off_y       = COORD_W'(b.radius);
            dec         = DEC_W'(3 - 2 * int'(b.radius));
            circ_active = 1'b1;
        end else if (!circ_active) begin
            return;     // step with no circle: absorbed silently
        end
        cxi = int'(ctr_x);
        cyi = int'(ctr_y);
        x   = int'(off_x);
        y   = int'(off_y);
        d   = int'(dec);
        nx  = x + 1;
        ny  = y;
        if (d < 0) begin
            d = d + 4 * nx + 6;
        end else begin
            d  = d + 4 * (nx - y) + 10;
            ny = y - 1;
        end
        fin = nx > ny;
        // Octant order: four points on the x offset, then four mirrored
        px = '{cxi + x, cxi - x, cxi + x, cxi - x, cxi + y, cxi + y, cxi - y, cxi - y};
        py = '{cyi + y, cyi + y, cyi - y, cyi - y, cyi + x, cyi - x, cyi + x, cyi - x};
        for (int k = 0; k < 8; k++) begin
            pt.pixel_x  = PIX_W'(px[k]);
            pt.pixel_y  = PIX_W'(py[k]);
            pt.visible  = px[k] > 0 && px[k] < int'(clip_w) &&
                          py[k] > 0 && py[k] < int'(clip_h);
            pt.last     = (k == LAST_POINT);
            pt.finished = fin;
            points_due.push_back(pt);
        end
        off_x       = COORD_W'(nx);
        off_y       = COORD_W'(ny);
        dec         = DEC_W'(d);
        circ_active = !fin;
        n_emitting++;
    endfunction

    task automatic queue_beat(input logic op, input logic [COORD_W-1:0] cx,
                              input logic [COORD_W-1:0] cy, input logic [RAD_W-1:0] r,
                              input bit drain);
        t_pending p;
        p.beat.op       = op;
        p.beat.center_x = cx;
        p.beat.center_y = cy;
        p.beat.radius   = r;
        p.drain         = drain;
        beats_to_send.push_back(p);
    endtask

    // Half the centres land anywhere, half inside the clip window or just past its edge
    function automatic logic [COORD_W-1:0] pick_coord(input int lim);
        if ($urandom_range(0, 1) == 1) return COORD_W'($urandom_range(0, 1023));
        return COORD_W'($urandom_range(0, (lim + 16 > 1023) ? 1023 : lim + 16));
    endfunction

    // One circle: mostly run to completion, some cut short by the next start
    task automatic add_sequence(output int emitted);
        int r, n, steps, sel;
        logic [COORD_W-1:0] cx, cy;
        sel = $urandom_range(0, 99);
        if (sel < 8)       r = $urandom_range(0, 511);
        else if (sel < 25) r = $urandom_range(0, 63);
        else               r = $urandom_range(1, 15);
        n  = circle_len(r);
        cx = pick_coord(int'(clip_w));
        cy = pick_coord(int'(clip_h));
        sel = $urandom_range(0, 99);
        if (r > 63) begin
            steps = $urandom_range(0, 3);       // big circles: only the first few beats
        end else if (sel < 75) begin
            steps = n - 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        end else begin
            steps = $urandom_range(0, n - 1);
        end
        if ($urandom_range(0, 19) == 0) begin
            queue_beat(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom),
                       1'b0);
        end
        queue_beat(OP_START, cx, cy, RAD_W'(r), $urandom_range(0, 24) == 0);
        repeat (steps) begin
            queue_beat(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom),
                       1'b0);
        end
        emitted = 1 + ((steps < n) ? steps : n - 1);
    endtask

    // Block idle: nothing queued or in flight, no points owed, then a settling pause
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || i_in_valid || points_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_clip(input logic idx, input logic [CLIP_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_CLIP_WIDTH) clip_w = val;
        else                       clip_h = val;
    endtask

    task automatic run_phase(input logic [CLIP_W-1:0] w, input logic [CLIP_W-1:0] h,
                             input bit set_w, input bit set_h, input int quota);
        int got, e;
        wait_idle();
        if (set_w) write_clip(REG_CLIP_WIDTH, w);
        if (set_h) write_clip(REG_CLIP_HEIGHT, h);
        if (set_w || set_h) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
        end
        @(negedge i_clk);
        idle_in_en  = $urandom_range(0, 3) != 0;
        idle_out_en = $urandom_range(0, 3) != 0;
        n_settings++;
        got = 0;
        while (got < quota) begin
            add_sequence(e);
            got += e;
        end
    endtask

    // Driver: offers the head of the queue, holds it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_points(i_in_data);
                n_beats_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0 &&
                             (!beats_to_send[0].drain || points_due.size() == 0)) begin
                    i_in_data  <= beats_to_send[0].beat;
                    i_in_valid <= 1'b1;
                    void'(beats_to_send.pop_front());
                    if (idle_in_en) gap_left = draw_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, each accepted point against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (points_due.size() == 0) begin
                    $error("unexpected point beat: x=%0d y=%0d",
                           o_out_data.pixel_x, o_out_data.pixel_y);
                    n_mismatch++;
                end else begin
                    want = points_due.pop_front();
                    if (o_out_data.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d",
                               want.pixel_x, o_out_data.pixel_x);
                        n_mismatch++;
                    end
                    if (o_out_data.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d",
                               want.pixel_y, o_out_data.pixel_y);
                        n_mismatch++;
                    end
                    if (o_out_data.visible !== want.visible) begin
                        $error("visible: expected %0b, got %0b",
                               want.visible, o_out_data.visible);
                        n_mismatch++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_out_data.last);
                        n_mismatch++;
                    end
                    if (o_out_data.finished !== want.finished) begin
                        $error("finished: expected %0b, got %0b",
                               want.finished, o_out_data.finished);
                        n_mismatch++;
                    end
                    n_points++;
                    if (want.visible) n_visible++;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if (idle_out_en && $urandom_range(0, 3) == 0) begin
                stall_left = draw_gap();
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("circle_outline_rasterizer_core_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_CLIP_WIDTH;
        i_cfg_data  <= '0;
        clip_w      = CLIP_WIDTH_RESET;
        clip_h      = CLIP_HEIGHT_RESET;
        ctr_x       = '0;
        ctr_y       = '0;
        off_x       = '0;
        off_y       = '0;
        dec         = '0;
        circ_active = 1'b0;
        idle_in_en  = 1'b0;
        idle_out_en = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats on the reset clip window, no idling
        queue_beat(OP_STEP, '1, '1, '1, 1'b0);              // step with nothing active
        queue_beat(OP_START, 10'd100, 10'd100, 9'd0, 1'b0); // zero radius: centre x8
        queue_beat(OP_STEP, '0, '0, '0, 1'b0);              // circle already done
        queue_beat(OP_START, 10'd0, 10'd0, 9'd511, 1'b0);   // negative coordinates
        queue_beat(OP_STEP, '0, '0, '0, 1'b0);
        queue_beat(OP_STEP, '1, '1, '1, 1'b0);
        queue_beat(OP_START, 10'd1023, 10'd1023, 9'd511, 1'b0); // restart mid-circle
        queue_beat(OP_STEP, '0, '0, '0, 1'b0);
        queue_beat(OP_START, 10'd1, 10'd1, 9'd1, 1'b0);     // points on the zero edge
        queue_beat(OP_START, 10'd639, 10'd319, 9'd1, 1'b1); // far edge, sent after a drain
        queue_beat(OP_START, 10'd320, 10'd160, 9'd6, 1'b0);
        repeat (circle_len(6)) queue_beat(OP_STEP, '0, '0, '0, 1'b0);
        queue_beat(OP_START, 10'd1023, 10'd0, 9'd2, 1'b0);
        repeat (circle_len(2) - 1) queue_beat(OP_STEP, '1, '1, '1, 1'b0);
        queue_beat(OP_START, 10'd512, 10'd512, 9'd256, 1'b0);
        queue_beat(OP_STEP, '0, '0, '0, 1'b0);

        // Random phases across clip settings, extremes included
        run_phase(11'd2047, 11'd2047, 1'b1, 1'b1, 15);
        run_phase(11'd1, 11'd1, 1'b1, 1'b1, 15);
        run_phase(11'd0, 11'd0, 1'b1, 1'b1, 15);
        run_phase(11'd300, 11'd200, 1'b1, 1'b1, 15);
        run_phase(CLIP_W'($urandom_range(1, 2047)), CLIP_W'($urandom_range(1, 2047)),
                  1'b1, 1'b1, 15);
        run_phase(CLIP_W'($urandom_range(1, 2047)), 11'd0, 1'b1, 1'b0, 15);
        run_phase(11'd0, CLIP_W'($urandom_range(1, 2047)), 1'b0, 1'b1, 15);
        run_phase(CLIP_WIDTH_RESET, CLIP_HEIGHT_RESET, 1'b1, 1'b1, 15);

        wait_idle();
        repeat (8) @(negedge i_clk);
        $display("Run: %0d input beats sent, %0d of them producing points, %0d clip settings",
                 n_beats_sent, n_emitting, n_settings + 1);
        $display("Points: %0d checked, %0d inside the clip window, %0d mismatches",
                 n_points, n_visible, n_mismatch);
        if (n_mismatch == 0) begin
            $display("circle_outline_rasterizer_core_tb: done, clean");
        end else begin
            $display("circle_outline_rasterizer_core_tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cor_pkg.sv
hdl/cor_step.sv
hdl/cor_emit.sv
hdl/circle_outline_rasterizer_core.sv
hdl/cor_checker.sv
sim/circle_outline_rasterizer_core_tb.sv
